/* sv/klc_pkg.sv */
// Shared types, codes and constants for the keyboard LED command handshake.
package klc_pkg;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		REG_TRY_LIMIT    = 2'd0,
		REG_COMMAND_CODE = 2'd1,
		REG_ACK_CODE     = 2'd2,
		REG_RESEND_CODE  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_STATUS   = 2'd1,
		OP_RESPONSE = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_START,
		EV_TIMEOUT,
		EV_ACK,
		EV_RESEND,
		EV_OTHER
	} ev_cls_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMD,
		PH_ARG
	} phase_t;

	localparam logic [3:0] TRY_LIMIT_RST    = 4'd10;
	localparam logic [7:0] COMMAND_CODE_RST = 8'd237;
	localparam logic [7:0] ACK_CODE_RST     = 8'd250;
	localparam logic [7:0] RESEND_CODE_RST  = 8'd254;
	localparam logic [3:0] TRY_MAX          = 4'd15;

	typedef struct packed {
		logic [3:0] try_limit;
		logic [7:0] command_code;
		logic [7:0] ack_code;
		logic [7:0] resend_code;
	} cfg_t;

	typedef struct packed {
		ev_cls_t    cls;
		logic [2:0] mask;
	} ev_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       done_res;
		logic       failed;
		logic [2:0] led_status_out;
	} res_t;

endpackage

/* sv/klc_front.sv */
// Front end: accepts input words, classifies them and queues the events.
module klc_front import klc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [2:0] led_mask,
	input  logic       timeout_flag,
	input  logic [7:0] response_byte,
	input  cfg_t       cfg,
	output logic       ev_valid,
	output ev_t        ev,
	input  logic       ev_take
);

	ev_t        mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	ev_t        ev_new;
	logic       do_push;

	always_comb begin
		ev_new.mask = led_mask;
		case (op_t'(operation))
			OP_START:    ev_new.cls = EV_START;
			OP_STATUS:   ev_new.cls = timeout_flag ? EV_TIMEOUT : EV_NONE;
			OP_RESPONSE: begin
				if (response_byte == cfg.ack_code)
					ev_new.cls = EV_ACK;
				else if (response_byte == cfg.resend_code)
					ev_new.cls = EV_RESEND;
				else
					ev_new.cls = EV_OTHER;
			end
			default:     ev_new.cls = EV_NONE;
		endcase
	end

	assign full     = (count_q == 2'(QDEPTH));
	assign ev_valid = (count_q != 2'd0);
	assign do_push  = push && !full;
	assign ev       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= ev_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (ev_take)
				rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, ev_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/klc_back.sv */
// Back end: exchange state machine and result queue.
module klc_back import klc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic ev_valid,
	input  ev_t  ev,
	output logic ev_take,
	input  logic pop,
	output logic empty,
	output res_t res
);

	phase_t     phase_q, phase_d;
	logic [3:0] try_q, try_d;
	logic [2:0] mask_q, mask_d;
	logic [2:0] led_q, led_d;
	logic [3:0] try_inc;
	logic       hit;
	logic       active;
	res_t       res_new;

	res_t       mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign active  = (phase_q == PH_CMD) || (phase_q == PH_ARG);
	assign try_inc = (try_q == TRY_MAX) ? TRY_MAX : try_q + 4'd1;
	assign hit     = (try_inc >= cfg.try_limit);

	// next state
	always_comb begin
		phase_d = phase_q;
		try_d   = try_q;
		mask_d  = mask_q;
		led_d   = led_q;
		case (ev.cls)
			EV_START: begin
				mask_d  = ev.mask;
				try_d   = 4'd0;
				phase_d = (cfg.try_limit == 4'd0) ? PH_IDLE : PH_CMD;
			end
			EV_TIMEOUT: begin
				if (active) begin
					try_d = try_inc;
					if (hit)
						phase_d = PH_IDLE;
				end
			end
			EV_ACK: begin
				if (phase_q == PH_CMD) begin
					phase_d = PH_ARG;
				end else if (phase_q == PH_ARG) begin
					phase_d = PH_IDLE;
					led_d   = mask_q;
				end
			end
			EV_RESEND, EV_OTHER: begin
				if (active) begin
					try_d = try_inc;
					if (hit)
						phase_d = PH_IDLE;
					else if (ev.cls == EV_OTHER)
						phase_d = PH_CMD;
				end
			end
			default: ;
		endcase
	end

	// result word
	always_comb begin
		res_new                = '0;
		res_new.led_status_out = led_d;
		case (ev.cls)
			EV_START: begin
				if (cfg.try_limit == 4'd0) begin
					res_new.failed = 1'b1;
				end else begin
					res_new.send_valid = 1'b1;
					res_new.send_byte  = cfg.command_code;
				end
			end
			EV_TIMEOUT: res_new.failed = active && hit;
			EV_ACK: begin
				if (phase_q == PH_CMD) begin
					res_new.send_valid = 1'b1;
					res_new.send_byte  = {5'd0, mask_q};
				end else if (phase_q == PH_ARG) begin
					res_new.done_res = 1'b1;
				end
			end
			EV_RESEND, EV_OTHER: begin
				if (active) begin
					if (hit) begin
						res_new.failed = 1'b1;
					end else begin
						res_new.send_valid = 1'b1;
						if (phase_q == PH_ARG && ev.cls == EV_RESEND)
							res_new.send_byte = {5'd0, mask_q};
						else
							res_new.send_byte = cfg.command_code;
					end
				end
			end
			default: ;
		endcase
	end

	assign ev_take = ev_valid && (count_q != 2'(QDEPTH));
	assign empty   = (count_q == 2'd0);
	assign do_pop  = pop && !empty;
	assign res     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ev_take)
			mem_q[wr_ptr_q] <= res_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			try_q    <= 4'd0;
			mask_q   <= 3'd0;
			led_q    <= 3'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (ev_take) begin
				phase_q  <= phase_d;
				try_q    <= try_d;
				mask_q   <= mask_d;
				led_q    <= led_d;
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({ev_take, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/keyboard_led_command_handshake.sv */
// Host side of the keyboard set-LEDs exchange: one result word per input word.
// Every input word yields exactly one result word. The block takes one word per
// clock while full is low; a pushed word is classified into a two-entry event
// queue and its result, computed by the exchange state machine in the back end,
// is written to the result queue when the back end takes the event. Sustained
// throughput is one word per cycle while the result side pops. Each side has
// two entries of buffering. Configuration writes take effect on the next clock
// and should be made while no words are in flight.
module keyboard_led_command_handshake import klc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [2:0] led_mask,
	input  logic       timeout_flag,
	input  logic [7:0] response_byte,
	output logic       empty,
	input  logic       pop,
	output logic       send_valid,
	output logic [7:0] send_byte,
	output logic       done_res,
	output logic       failed,
	output logic [2:0] led_status_out,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t cfg_q;
	logic ev_valid;
	ev_t  ev;
	logic ev_take;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.try_limit    <= TRY_LIMIT_RST;
			cfg_q.command_code <= COMMAND_CODE_RST;
			cfg_q.ack_code     <= ACK_CODE_RST;
			cfg_q.resend_code  <= RESEND_CODE_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TRY_LIMIT:    cfg_q.try_limit    <= cfg_data[3:0];
				REG_COMMAND_CODE: cfg_q.command_code <= cfg_data;
				REG_ACK_CODE:     cfg_q.ack_code     <= cfg_data;
				REG_RESEND_CODE:  cfg_q.resend_code  <= cfg_data;
				default: ;
			endcase
		end
	end

	klc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.led_mask     (led_mask),
		.timeout_flag (timeout_flag),
		.response_byte(response_byte),
		.cfg          (cfg_q),
		.ev_valid     (ev_valid),
		.ev           (ev),
		.ev_take      (ev_take)
	);

	klc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.ev_valid(ev_valid),
		.ev      (ev),
		.ev_take (ev_take),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign send_valid     = res.send_valid;
	assign send_byte      = res.send_byte;
	assign done_res       = res.done_res;
	assign failed         = res.failed;
	assign led_status_out = res.led_status_out;

`ifndef SYNTHESIS
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !((send_valid && done_res) || (send_valid && failed) || (done_res && failed)))
		else $error("result word has more than one outcome");
	a_nosend_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !send_valid) |-> (send_byte == 8'd0))
		else $error("send byte nonzero without send");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && empty) |=> !empty)
		else $error("queued event did not produce a result");
`endif

endmodule

/* dv/tb.sv */
// Testbench for the keyboard LED command handshake: directed table, then random words.
module tb;
	import klc_pkg::*;

	typedef struct packed {
		op_t        op;
		logic [2:0] mask;
		logic       tmo;
		logic [7:0] rb;
	} word_t;

	typedef struct {
		word_t      w;
		logic [3:0] lim;
		bit         known;
		res_t       res;
	} dir_row_t;

	localparam res_t QUIET = '0;
	localparam res_t FAIL5 = {1'b0, 8'd0, 1'b0, 1'b1, 3'd5};

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [1:0] operation;
	logic [2:0] led_mask;
	logic       timeout_flag;
	logic [7:0] response_byte;
	logic       empty;
	logic       pop;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       done_res;
	logic       failed;
	logic [2:0] led_status_out;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	keyboard_led_command_handshake dut (.*);

	// predictor state
	cfg_t       cfg;
	phase_t     hs_phase;
	logic [3:0] tries;
	logic [2:0] held_mask;
	logic [2:0] leds;

	res_t     awaited_q[$];
	dir_row_t dir_rows[$];
	int       mismatches = 0;
	int       idle_mode = 2;
	int       hold_reqs = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 200000);
		$display("tb: failure");
		$finish;
	end

	function automatic bit spend_try();
		if (tries != TRY_MAX)
			tries = tries + 4'd1;
		if (tries >= cfg.try_limit) begin
			hs_phase = PH_IDLE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic res_t step_handshake(word_t w);
		res_t r;
		bit   busy;
		r = '0;
		busy = (hs_phase == PH_CMD) || (hs_phase == PH_ARG);
		case (w.op)
			OP_START: begin
				held_mask = w.mask;
				tries = 4'd0;
				if (cfg.try_limit == 4'd0) begin
					hs_phase = PH_IDLE;
					r.failed = 1'b1;
				end else begin
					hs_phase = PH_CMD;
					r.send_valid = 1'b1;
					r.send_byte = cfg.command_code;
				end
			end
			OP_STATUS: begin
				if (busy && w.tmo)
					r.failed = spend_try();
			end
			OP_RESPONSE: begin
				if (busy && hs_phase == PH_CMD) begin
					if (w.rb == cfg.ack_code) begin
						hs_phase = PH_ARG;
						r.send_valid = 1'b1;
						r.send_byte = {5'd0, held_mask};
					end else if (spend_try()) begin
						r.failed = 1'b1;
					end else begin
						r.send_valid = 1'b1;
						r.send_byte = cfg.command_code;
					end
				end else if (busy) begin
					if (w.rb == cfg.ack_code) begin
						leds = held_mask;
						hs_phase = PH_IDLE;
						r.done_res = 1'b1;
					end else if (spend_try()) begin
						r.failed = 1'b1;
					end else if (w.rb == cfg.resend_code) begin
						r.send_valid = 1'b1;
						r.send_byte = {5'd0, held_mask};
					end else begin
						hs_phase = PH_CMD;
						r.send_valid = 1'b1;
						r.send_byte = cfg.command_code;
					end
				end
			end
			default: ;
		endcase
		r.led_status_out = leds;
		return r;
	endfunction

	// mostly well-formed exchanges, some noise and broken ones
	function automatic word_t next_word();
		word_t w;
		int    r;
		w.op = OP_START;
		w.mask = 3'($urandom_range(0, 7));
		w.tmo = 1'($urandom_range(0, 1));
		w.rb = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (hs_phase == PH_IDLE) begin
			if (r >= 85)
				w.op = op_t'($urandom_range(1, 3));
		end else if (r < 8) begin
			w.op = OP_START;
		end else if (r < 30) begin
			w.op = OP_STATUS;
			w.tmo = ($urandom_range(0, 3) == 0);
		end else if (r < 65) begin
			w.op = OP_RESPONSE;
			w.rb = cfg.ack_code;
		end else if (r < 75) begin
			w.op = OP_RESPONSE;
			w.rb = cfg.resend_code;
		end else if (r < 80) begin
			w.op = OP_RESPONSE;
			w.rb = cfg.command_code;
		end else if (r < 92) begin
			w.op = OP_RESPONSE;
		end else begin
			w.op = op_t'($urandom_range(0, 3));
		end
		return w;
	endfunction

	task automatic add_row(op_t op, logic [2:0] mask, logic tmo, logic [7:0] rb,
			logic [3:0] lim, bit known, res_t res);
		dir_row_t d;
		d.w = {op, mask, tmo, rb};
		d.lim = lim;
		d.known = known;
		d.res = res;
		dir_rows.push_back(d);
	endtask

	task automatic send_word(word_t w, bit known = 1'b0, res_t typed = '0);
		int   pct;
		res_t p;
		pct = (idle_mode == 0) ? 20 : (idle_mode == 1) ? 51 : 0;
		@(negedge clk);
		while ($urandom_range(0, 99) < pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		operation <= w.op;
		led_mask <= w.mask;
		timeout_flag <= w.tmo;
		response_byte <= w.rb;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		p = step_handshake(w);
		awaited_q.push_back(known ? typed : p);
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (awaited_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TRY_LIMIT:    cfg.try_limit = val[3:0];
			REG_COMMAND_CODE: cfg.command_code = val;
			REG_ACK_CODE:     cfg.ack_code = val;
			REG_RESEND_CODE:  cfg.resend_code = val;
			default: ;
		endcase
	endtask

	// result side: random pops, plus a long hold-off on request
	initial begin
		int   pct;
		int   hold_left;
		int   hold_done;
		res_t e;
		pop = 1'b0;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_done != hold_reqs) begin
				hold_left = 80;
				hold_done++;
			end
			pct = (idle_mode == 0) ? 51 : (idle_mode == 1) ? 20 : 0;
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(0, 99) >= pct);
			end
			@(posedge clk);
			if (pop && empty === 1'b0) begin
				if (awaited_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: sv=%0b byte=%0d done=%0b fail=%0b leds=%0d",
							send_valid, send_byte, done_res, failed, led_status_out);
				end else begin
					e = awaited_q.pop_front();
					if (send_valid !== e.send_valid || send_byte !== e.send_byte ||
							done_res !== e.done_res || failed !== e.failed ||
							led_status_out !== e.led_status_out) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected sv=%0b byte=%0d done=%0b fail=%0b leds=%0d, %s",
								e.send_valid, e.send_byte, e.done_res, e.failed,
								e.led_status_out, $sformatf(
								"got sv=%0b byte=%0d done=%0b fail=%0b leds=%0d",
								send_valid, send_byte, done_res, failed, led_status_out));
					end
				end
			end
		end
	end

	initial begin
		int         seg;
		int         n;
		logic [3:0] lim;
		logic [7:0] cmd;
		logic [7:0] ack;
		logic [7:0] rsd;

		arst_n = 1'b0;
		push = 1'b0;
		operation = OP_NONE;
		led_mask = 3'd0;
		timeout_flag = 1'b0;
		response_byte = 8'd0;
		cfg_we = 1'b0;
		cfg_index = REG_TRY_LIMIT;
		cfg_data = 8'd0;
		cfg = {TRY_LIMIT_RST, COMMAND_CODE_RST, ACK_CODE_RST, RESEND_CODE_RST};
		hs_phase = PH_IDLE;
		tries = 4'd0;
		held_mask = 3'd0;
		leds = 3'd0;

		// idle events, then a full exchange with retries and a restarted one at reset settings
		add_row(OP_STATUS,   3'd0, 1'b1, 8'd0,   4'd10, 1'b1, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd250, 4'd10, 1'b1, QUIET);
		add_row(OP_NONE,     3'd7, 1'b1, 8'd255, 4'd10, 1'b1, QUIET);
		add_row(OP_START,    3'd7, 1'b0, 8'd0,   4'd10, 1'b1,
			{1'b1, 8'd237, 1'b0, 1'b0, 3'd0});
		add_row(OP_STATUS,   3'd0, 1'b0, 8'd0,   4'd10, 1'b0, QUIET);
		add_row(OP_STATUS,   3'd0, 1'b1, 8'd0,   4'd10, 1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd0,   4'd10, 1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd250, 4'd10, 1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd254, 4'd10, 1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd255, 4'd10, 1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd250, 4'd10, 1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd250, 4'd10, 1'b0, QUIET);
		add_row(OP_START,    3'd0, 1'b0, 8'd0,   4'd10, 1'b0, QUIET);
		add_row(OP_START,    3'd5, 1'b0, 8'd0,   4'd10, 1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd250, 4'd10, 1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd250, 4'd10, 1'b0, QUIET);
		// single try: every failure path
		add_row(OP_START,    3'd3, 1'b0, 8'd0,   4'd1,  1'b0, QUIET);
		add_row(OP_STATUS,   3'd0, 1'b1, 8'd0,   4'd1,  1'b1, FAIL5);
		add_row(OP_START,    3'd2, 1'b0, 8'd0,   4'd1,  1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd0,   4'd1,  1'b1, FAIL5);
		add_row(OP_START,    3'd6, 1'b0, 8'd0,   4'd1,  1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd250, 4'd1,  1'b0, QUIET);
		add_row(OP_RESPONSE, 3'd0, 1'b0, 8'd254, 4'd1,  1'b1, FAIL5);
		// zero tries: start fails at once
		add_row(OP_START,    3'd4, 1'b0, 8'd0,   4'd0,  1'b1, FAIL5);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].lim != cfg.try_limit) begin
				drain();
				write_reg(REG_TRY_LIMIT, {4'd0, dir_rows[i].lim});
			end
			send_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].res);
		end

		for (seg = 0; seg < 9; seg++) begin
			drain();
			case (seg)
				0: begin
					lim = 4'd10; cmd = 8'd237; ack = 8'd250; rsd = 8'd254;
				end
				1: begin
					lim = 4'd1; cmd = 8'd0; ack = 8'd255; rsd = 8'd0;
				end
				2: begin
					lim = 4'd15; cmd = 8'd255; ack = 8'd0; rsd = 8'd255;
				end
				default: begin
					lim = 4'($urandom_range(1, 15));
					cmd = 8'($urandom_range(0, 255));
					ack = 8'($urandom_range(0, 255));
					rsd = (seg == 5) ? ack : 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(REG_TRY_LIMIT, {4'd0, lim});
			write_reg(REG_COMMAND_CODE, cmd);
			write_reg(REG_ACK_CODE, ack);
			write_reg(REG_RESEND_CODE, rsd);
			idle_mode = seg / 3;
			if (seg == 1 || seg == 6)
				hold_reqs++;
			for (n = 0; n < 130; n++)
				send_word(next_word());
		end

		drain();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
sv/klc_pkg.sv
sv/klc_front.sv
sv/klc_back.sv
sv/keyboard_led_command_handshake.sv
dv/tb.sv
